// ----- src/bfns_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfns_pkg
// Operation codes and fixed field widths for the bitmap find-next-set block.
// ----------------------------------------------------------------------------
package bfns_pkg;

  // fixed field widths
  localparam int POS_W  = 16;
  localparam int MODE_W = 3;

  // operation codes carried on the mode field
  localparam logic [MODE_W-1:0] MODE_SET   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TEST  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FIND  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_GAP   = 3'd4;

endpackage

// ----- src/bitmap_find_next_set.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_find_next_set
// Word-organized bitmap with set, clear, test, find-next-set and minimum-gap.
// ----------------------------------------------------------------------------
// After reset the block sweeps the bitmap memory to zero, one word per cycle,
// and in_ready stays low until the sweep ends; cfg writes are taken at any
// time. Items are handled one at a time and the result holds on out_value
// until its transfer. Addressed positions, search starts and the limit go
// through a divide-by-WORD_BITS unit (reciprocal multiply, then one
// correction), and the memory has one read port with a registered output,
// so each word is read in ST_READ and looked at in ST_WORD. Set, clear and
// test split the position, read its word and write it back or test the bit;
// unknown modes, a find that starts at or past the limit and a minimum-gap
// with a zero limit go straight to the result. Find-next splits the limit,
// then the start, and walks words up to the limit word, through ST_HIT on a
// hit. Minimum-gap splits the limit, then steps from each set position to
// the next until it reaches the limit.
// ----------------------------------------------------------------------------
module bitmap_find_next_set
  import bfns_pkg::*;
#(
  parameter int WORD_COUNT = 1024,
  parameter int WORD_BITS  = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [POS_W-1:0]  in_position,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [POS_W-1:0]  out_value,
  input  logic              cfg_we,
  input  logic [POS_W-1:0]  cfg_wdata
);

  // derived sizes
  localparam int AW     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int OW     = $clog2(WORD_BITS);
  localparam int QW     = $clog2(65535 / WORD_BITS + 2);
  localparam int SHIFT  = 24;
  localparam int RECIP  = (1 << SHIFT) / WORD_BITS;
  localparam int RW     = $clog2(RECIP + 1);
  localparam int PW     = POS_W + RW;
  localparam int HW     = POS_W + 1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIVQ,
    ST_DIVR,
    ST_READ,
    ST_WORD,
    ST_HIT,
    ST_STEP,
    ST_DONE
  } state_t;

  state_t                state_r;
  logic [AW-1:0]         clr_r;
  logic [POS_W-1:0]      limit_r;
  logic [MODE_W-1:0]     mode_r;
  logic [POS_W-1:0]      div_a_r;
  logic                  div_lim_r;
  logic [QW-1:0]         q_r;
  logic [QW-1:0]         last_r;
  logic [QW-1:0]         idx_r;
  logic [OW-1:0]         off_r;
  logic                  first_r;
  logic                  rd_ok_r;
  logic [OW-1:0]         tz_r;
  logic [POS_W-1:0]      curr_r;
  logic [POS_W-1:0]      best_r;
  logic [POS_W-1:0]      nxt_r;
  logic [POS_W-1:0]      value_r;

  // bitmap memory
  logic [WORD_BITS-1:0]  mem [WORD_COUNT];
  logic [WORD_BITS-1:0]  rdata_r;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [WORD_BITS-1:0]  mem_wdata;
  logic                  mem_re;

  // divide unit, stage one: reciprocal multiply
  logic [PW-1:0]         prod;
  logic [QW-1:0]         q_est;
  assign prod  = PW'(div_a_r) * PW'(RECIP);
  assign q_est = QW'(prod >> SHIFT);

  // divide unit, stage two: remainder and one correction step
  logic [HW-1:0]         qmul;
  logic [HW-1:0]         rem_full;
  logic [OW:0]           rem_est;
  logic [QW-1:0]         q_fix;
  logic [OW-1:0]         r_fix;
  assign qmul     = HW'(q_r) * HW'(WORD_BITS);
  assign rem_full = {1'b0, div_a_r} - qmul;
  assign rem_est  = rem_full[OW:0];
  always_comb begin
    if (rem_est >= (OW+1)'(WORD_BITS)) begin
      q_fix = q_r + QW'(1);
      r_fix = OW'(rem_est - (OW+1)'(WORD_BITS));
    end else begin
      q_fix = q_r;
      r_fix = OW'(rem_est);
    end
  end

  // word under scan, masked below the start offset on the first word
  logic [WORD_BITS-1:0]  bit_sel;
  logic [WORD_BITS-1:0]  word_in;
  logic [WORD_BITS-1:0]  scan_w;
  logic [WORD_BITS-1:0]  low_bit;
  logic [OW-1:0]         tz;
  assign bit_sel = WORD_BITS'(1) << off_r;
  assign word_in = rd_ok_r ? rdata_r : '0;
  assign scan_w  = first_r ? (word_in & ({WORD_BITS{1'b1}} << off_r)) : word_in;
  assign low_bit = scan_w & (~scan_w + WORD_BITS'(1));

  // one-hot to binary for the lowest set bit
  always_comb begin
    tz = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low_bit[i]) begin
        tz = tz | OW'(i);
      end
    end
  end

  // hit position; clamped to the limit in ST_HIT
  logic [HW-1:0]         hit_pos;
  assign hit_pos = HW'(idx_r) * HW'(WORD_BITS) + HW'(tz_r);

  // gap update
  logic [POS_W-1:0]      gap_len;
  logic [POS_W-1:0]      best_nxt;
  assign gap_len  = nxt_r - curr_r;
  assign best_nxt = (gap_len < best_r) ? gap_len : best_r;

  logic                  idx_in_range;
  assign idx_in_range = (32'(idx_r) < WORD_COUNT);

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(idx_r);
    mem_wdata = rdata_r | bit_sel;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = '0;
    end else if (state_r == ST_WORD && rd_ok_r &&
                 (mode_r == MODE_SET || mode_r == MODE_CLEAR)) begin
      mem_we    = 1'b1;
      mem_wdata = (mode_r == MODE_SET) ? (rdata_r | bit_sel) : (rdata_r & ~bit_sel);
    end
  end
  assign mem_re = (state_r == ST_READ) && idx_in_range;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[AW'(idx_r)];
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '1;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(WORD_COUNT - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            mode_r  <= in_mode;
            first_r <= 1'b1;
            unique case (in_mode)
              MODE_SET, MODE_CLEAR, MODE_TEST: begin
                div_a_r   <= in_position;
                div_lim_r <= 1'b0;
                state_r   <= ST_DIVQ;
              end
              MODE_FIND: begin
                if (in_position >= limit_r) begin
                  value_r <= limit_r;
                  state_r <= ST_DONE;
                end else begin
                  curr_r    <= in_position;
                  div_a_r   <= limit_r;
                  div_lim_r <= 1'b1;
                  state_r   <= ST_DIVQ;
                end
              end
              MODE_GAP: begin
                best_r <= limit_r;
                curr_r <= '0;
                if (limit_r == '0) begin
                  value_r <= limit_r;
                  state_r <= ST_DONE;
                end else begin
                  div_a_r   <= limit_r;
                  div_lim_r <= 1'b1;
                  state_r   <= ST_DIVQ;
                end
              end
              default: begin
                value_r <= '0;
                state_r <= ST_DONE;
              end
            endcase
          end
        end
        ST_DIVQ: begin
          q_r     <= q_est;
          state_r <= ST_DIVR;
        end
        ST_DIVR: begin
          if (div_lim_r) begin
            // limit split done, now split the search start
            last_r     <= q_fix;
            div_a_r    <= curr_r + POS_W'(1);
            div_lim_r  <= 1'b0;
            state_r    <= ST_DIVQ;
          end else begin
            idx_r   <= q_fix;
            off_r   <= r_fix;
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          rd_ok_r <= idx_in_range;
          state_r <= ST_WORD;
        end
        ST_WORD: begin
          priority if (mode_r == MODE_SET || mode_r == MODE_CLEAR) begin
            value_r <= '0;
            state_r <= ST_DONE;
          end else if (mode_r == MODE_TEST) begin
            value_r <= POS_W'(rd_ok_r & rdata_r[off_r]);
            state_r <= ST_DONE;
          end else if (scan_w != '0) begin
            tz_r    <= tz;
            state_r <= ST_HIT;
          end else if (idx_r >= last_r) begin
            // no set bit up to the end of the limit word
            nxt_r   <= limit_r;
            state_r <= ST_STEP;
          end else begin
            idx_r   <= idx_r + QW'(1);
            first_r <= 1'b0;
            state_r <= ST_READ;
          end
        end
        ST_HIT: begin
          nxt_r   <= (hit_pos > HW'(limit_r)) ? limit_r : POS_W'(hit_pos);
          state_r <= ST_STEP;
        end
        ST_STEP: begin
          if (mode_r == MODE_FIND) begin
            value_r <= nxt_r;
            state_r <= ST_DONE;
          end else begin
            best_r <= best_nxt;
            curr_r <= nxt_r;
            if (nxt_r < limit_r) begin
              div_a_r <= nxt_r + POS_W'(1);
              first_r <= 1'b1;
              state_r <= ST_DIVQ;
            end else begin
              value_r <= best_nxt;
              state_r <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (out_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // handshake outputs
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
  assign out_value = value_r;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bitmap find-next-set block. A behavioral copy
// of the bitmap and the limit register works out each value as an item
// transfers in. A checker compares every output transfer with the oldest
// value still due. Directed items cover the edge cases. Random phases then
// sweep several limits, with random idle bursts on both channels but in the last.
// ----------------------------------------------------------------------------
module testbench;
  import bfns_pkg::*;

  localparam int WORD_COUNT = 1024;
  localparam int WORD_BITS  = 64;
  localparam int MAX_CYCLES = 10000000;
  localparam int TAIL_CYCLES = 64;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [MODE_W-1:0] in_mode;
  logic [POS_W-1:0]  in_position;
  logic              out_valid;
  logic              out_ready;
  logic [POS_W-1:0]  out_value;
  logic              cfg_we;
  logic [POS_W-1:0]  cfg_wdata;

  // behavioral copy of the block state
  logic [WORD_BITS-1:0] occ_words [WORD_COUNT];
  logic [POS_W-1:0]     limit_reg;

  logic [POS_W-1:0] due_values [$];
  int               error_count;
  int               cycle_count;
  bit               idle_en;

  bitmap_find_next_set #(
    .WORD_COUNT(WORD_COUNT),
    .WORD_BITS (WORD_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_mode    (in_mode),
    .in_position(in_position),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // first set position after pos, up to the limit; the limit when none
  function automatic int unsigned next_set_after(input int unsigned pos);
    int unsigned start;
    int unsigned idx;
    int unsigned last;
    int unsigned hit;
    int unsigned n;
    logic [WORD_BITS-1:0] w;
    start = pos + 1;
    if (start > limit_reg) return limit_reg;
    idx  = start / WORD_BITS;
    last = limit_reg / WORD_BITS;
    w = occ_words[idx] & ({WORD_BITS{1'b1}} << (start % WORD_BITS));
    while (w == '0) begin
      idx++;
      if (idx > last) return limit_reg;
      w = occ_words[idx];
    end
    n = 0;
    while (n < WORD_BITS - 1 && !w[n]) n++;
    hit = idx * WORD_BITS + n;
    return (hit > limit_reg) ? limit_reg : hit;
  endfunction

  // smallest step between successive set positions from 0 to the limit
  function automatic int unsigned smallest_gap();
    int unsigned best;
    int unsigned cur;
    int unsigned nxt;
    best = limit_reg;
    cur  = 0;
    while (cur < limit_reg) begin
      nxt = next_set_after(cur);
      if (nxt - cur < best) best = nxt - cur;
      cur = nxt;
    end
    return best;
  endfunction

  // apply one item to the bitmap copy and return the value it yields
  function automatic logic [POS_W-1:0] bitmap_op(input logic [MODE_W-1:0] mode,
                                                 input logic [POS_W-1:0] pos);
    logic [POS_W-1:0] result;
    int unsigned      widx;
    int unsigned      bidx;
    result = '0;
    widx = pos / WORD_BITS;
    bidx = pos % WORD_BITS;
    case (mode)
      MODE_SET: begin
        if (widx < WORD_COUNT) occ_words[widx][bidx] = 1'b1;
      end
      MODE_CLEAR: begin
        if (widx < WORD_COUNT) occ_words[widx][bidx] = 1'b0;
      end
      MODE_TEST: begin
        if (widx < WORD_COUNT) result = POS_W'(occ_words[widx][bidx]);
      end
      MODE_FIND: result = POS_W'(next_set_after(pos));
      MODE_GAP:  result = POS_W'(smallest_gap());
      default:   result = '0;
    endcase
    return result;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    logic [POS_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (due_values.size() == 0) begin
        report_error($sformatf("result transfer with nothing due, value %0d", out_value));
      end else begin
        want = due_values.pop_front();
        if (out_value !== want)
          report_error($sformatf("value got %0d want %0d", out_value, want));
      end
    end
  end

  // receiver stalls in random bursts
  always begin
    @(posedge clk);
    if (idle_en && $urandom_range(0, 15) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    out_ready <= 1'b1;
  end

  // send one item, with an optional idle burst in front
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_position <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    due_values.push_back(bitmap_op(mode, pos));
  endtask

  // hold off until every due value has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (due_values.size() != 0) @(posedge clk);
  endtask

  // limit register write; only called after drain_results, with no item due
  task automatic write_limit(input logic [POS_W-1:0] lim);
    cfg_we    <= 1'b1;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_reg = lim;
  endtask

  // each operation, word edges, start past limit and unknown modes
  task automatic test_basic_ops();
    drain_results();
    write_limit(16'hFFFF);
    send_item(MODE_TEST, 16'd0);
    send_item(MODE_FIND, 16'd0);
    send_item(MODE_SET, 16'd0);
    send_item(MODE_SET, 16'hFFFF);
    send_item(MODE_SET, 16'd63);
    send_item(MODE_SET, 16'd64);
    send_item(MODE_TEST, 16'hFFFF);
    send_item(MODE_FIND, 16'd0);
    send_item(MODE_FIND, 16'd63);
    send_item(MODE_FIND, 16'd64);
    send_item(MODE_FIND, 16'hFFFF);
    send_item(MODE_GAP, 16'h1234);
    send_item(MODE_CLEAR, 16'd64);
    send_item(MODE_TEST, 16'd64);
    send_item(3'd5, 16'hFFFF);
    send_item(3'd6, 16'hAAAA);
    send_item(3'd7, 16'h5555);
  endtask

  // zero limit, hit clamped to the limit, limit on a word edge
  task automatic test_limit_edges();
    drain_results();
    write_limit(16'd0);
    send_item(MODE_GAP, 16'd0);
    send_item(MODE_FIND, 16'd0);
    drain_results();
    write_limit(16'd100);
    send_item(MODE_SET, 16'd120);
    send_item(MODE_FIND, 16'd90);
    drain_results();
    write_limit(16'd64);
    send_item(MODE_GAP, 16'd0);
    send_item(MODE_CLEAR, 16'd0);
    send_item(MODE_CLEAR, 16'd63);
    send_item(MODE_CLEAR, 16'd120);
  endtask

  // one phase of random traffic; positions mostly in [lo, hi]
  task automatic random_phase(input int unsigned lim, input int unsigned lo,
                              input int unsigned hi, input int count);
    int unsigned       r;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  pos;
    drain_results();
    write_limit(POS_W'(lim));
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 33)      mode = MODE_SET;
      else if (r < 48) mode = MODE_CLEAR;
      else if (r < 66) mode = MODE_TEST;
      else if (r < 88) mode = MODE_FIND;
      else if (r < 94) mode = MODE_GAP;
      else             mode = MODE_W'($urandom_range(5, 7));
      r = $urandom_range(0, 19);
      if (r < 3)       pos = POS_W'($urandom_range(0, 65535));
      else if (r == 3) pos = POS_W'(lim);
      else             pos = POS_W'($urandom_range(lo, hi));
      send_item(mode, pos);
    end
  endtask

  // random traffic over a spread of limits, small ones mostly
  task automatic test_random_traffic();
    int unsigned lim;
    random_phase(65535, 0, 65535, 100);
    lim = $urandom_range(1, 63);
    random_phase(lim, 0, lim + 64, 100);
    lim = $urandom_range(64, 1023);
    random_phase(lim, 0, lim + 64, 100);
    lim = $urandom_range(1024, 4095);
    random_phase(lim, 0, lim + 64, 100);
    lim = $urandom_range(4096, 65535);
    random_phase(lim, lim - 512, (lim + 63 > 65535) ? 65535 : lim + 63, 100);
  endtask

  // closing stretch at full rate on both sides
  task automatic test_no_idle_traffic();
    int unsigned lim;
    idle_en = 1'b0;
    lim = $urandom_range(128, 2047);
    random_phase(lim, 0, lim + 64, 100);
  endtask

  initial begin
    foreach (occ_words[i]) occ_words[i] = '0;
    limit_reg   = 16'hFFFF;
    error_count = 0;
    cycle_count = 0;
    idle_en     = 1'b1;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_mode     <= MODE_SET;
    in_position <= '0;
    out_ready   <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_ops();
    test_limit_edges();
    test_random_traffic();
    test_no_idle_traffic();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
